FILE: hdl/rcsp_pkg.sv
// Shared types and constants of the RIFF chunk stream parser.
package rcsp_pkg;

   localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
   localparam logic [31:0] FCC_LIST = 32'h5453_494C;
   localparam logic [31:0] FCC_NCTG = 32'h6774_636E;

   localparam logic [15:0] DATE_FIRST_RESET  = 16'h0013;
   localparam logic [15:0] DATE_SECOND_RESET = 16'h0014;

   localparam logic CSR_DATE_FIRST  = 1'b0;
   localparam logic CSR_DATE_SECOND = 1'b1;

   typedef enum logic [2:0] {
      EV_RIFF  = 3'd0,
      EV_CHUNK = 3'd1,
      EV_LIST  = 3'd2,
      EV_TAG   = 3'd3,
      EV_DATE  = 3'd4,
      EV_ERROR = 3'd5
   } event_kind_type;

   typedef enum logic [1:0] {
      ERR_NOT_RIFF = 2'd0,
      ERR_OVERRUN  = 2'd1,
      ERR_TOO_DEEP = 2'd2
   } error_code_type;

   // One result item, as it leaves the parser.
   typedef struct packed {
      logic [1:0]  error_code;
      logic        last_of_tag;
      logic [7:0]  data_byte;
      logic [15:0] tag_id;
      logic [3:0]  nest_level;
      logic [31:0] chunk_size;
      logic [31:0] four_cc;
      logic [2:0]  event_kind;
   } event_type;

   localparam int EVENT_WIDTH = $bits(event_type);

endpackage

FILE: hdl/rcsp_parser.sv
// Front part: byte-serial RIFF parser that turns each byte into at most one event.
module rcsp_parser #(
   parameter int MAX_NEST = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        stream_byte,
   input  logic              frame_start,
   input  logic [15:0]       date_tag_first,
   input  logic [15:0]       date_tag_second,
   output logic              ev_valid,
   output rcsp_pkg::event_type ev_data
);
   import rcsp_pkg::*;

   localparam int LW = $clog2(MAX_NEST + 1);
   localparam int SW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   typedef enum logic [2:0] {
      PH_RIFF, PH_CHUNK, PH_SKIP, PH_TAGHDR, PH_TAGDATA, PH_TAIL, PH_IDLE
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [3:0]        count_ff, count_in;
   logic [31:0]       id_ff, id_in;
   logic [31:0]       size_ff, size_in;
   logic [LW-1:0]     lp_ff, lp_in;
   logic [31:0]       pay_ff, pay_in;
   logic [31:0]       area_ff, area_in;
   logic [31:0]       tail_ff, tail_in;
   logic [15:0]       tag_ff, tag_in;
   // Remaining byte count of each open level; closed levels are masked by zero flags.
   logic [31:0]       lvl_ff [MAX_NEST];
   logic [MAX_NEST-1:0] zero_ff, zero_in;
   logic              wr_en;
   logic [SW-1:0]     wr_idx;
   logic [31:0]       wr_val;
   logic              ev_valid_in;
   event_type         ev_in;

   // Level count after closing exhausted levels from the top one down, up to the first that is not exhausted.
   function automatic logic [LW-1:0] close_levels(input logic [LW-1:0] lp,
                                                  input logic [MAX_NEST-1:0] z);
      logic [LW-1:0] r;
      r = lp;
      for (int i = MAX_NEST; i >= 1; i--) begin
         if (r == LW'(i) && z[i-1]) r = LW'(i - 1);
      end
      return r;
   endfunction

   always_comb begin
      logic [3:0]  k;
      logic [31:0] idv, szv;
      logic [32:0] total, rest, body;
      logic        over;
      logic [LW-1:0] nlp;
      logic [31:0] inner, area;
      logic        fin;
      phase_type   ph;

      phase_in = phase_ff; count_in = count_ff; id_in = id_ff; size_in = size_ff;
      lp_in = lp_ff; pay_in = pay_ff; area_in = area_ff; tail_in = tail_ff;
      tag_in = tag_ff; zero_in = zero_ff;
      wr_en = 1'b0; wr_idx = '0; wr_val = '0;
      ev_valid_in = 1'b0; ev_in = '0;
      fin = 1'b0;
      total = '0; rest = '0; body = '0; over = 1'b0; inner = '0; area = '0;
      nlp = '0;

      ph = phase_ff; k = count_ff; idv = id_ff; szv = size_ff;
      if (frame_start) begin
         ph = PH_RIFF; k = '0; idv = '0; szv = '0;
         lp_in = '0; pay_in = '0; area_in = '0; tail_in = '0; tag_in = '0;
         zero_in = '1;
      end
      ev_in.nest_level = 4'(lp_in);
      phase_in = ph; count_in = k; id_in = idv; size_in = szv;

      if (byte_valid) begin
         unique case (ph)
            PH_RIFF, PH_CHUNK: begin
               if (k == 4'd0) begin idv = '0; szv = '0; end
               if (k == 4'd8) idv = '0;
               if (k < 4'd4) idv[8*k[1:0] +: 8] = stream_byte;
               else if (k < 4'd8) szv[8*k[1:0] +: 8] = stream_byte;
               else idv[8*k[1:0] +: 8] = stream_byte;
               id_in = idv; size_in = szv; count_in = k + 4'd1;
               if (ph == PH_RIFF) begin
                  if (k == 4'd7 && idv != FCC_RIFF) begin
                     ev_valid_in = 1'b1; ev_in.event_kind = EV_ERROR;
                     ev_in.four_cc = idv; ev_in.chunk_size = szv;
                     ev_in.error_code = ERR_NOT_RIFF;
                     phase_in = PH_IDLE;
                  end else if (k == 4'd11) begin
                     ev_valid_in = 1'b1; ev_in.event_kind = EV_RIFF;
                     ev_in.four_cc = idv; ev_in.chunk_size = szv;
                     wr_en = 1'b1; wr_idx = '0;
                     wr_val = (szv < 32'd4) ? 32'd0 : szv - 32'd4;
                     zero_in[0] = (wr_val == 32'd0);
                     lp_in = LW'(1);
                     fin = 1'b1;
                  end
               end else if (k == 4'd7) begin
                  // Chunk header complete: charge the parent level.
                  rest  = zero_in[SW'(lp_in - LW'(1))] ? 33'd0
                        : {1'b0, lvl_ff[SW'(lp_in - LW'(1))]};
                  total = 33'd8 + ((33'(szv) + 33'd1) & ~33'd1);
                  over  = total > rest;
                  if (over) total = rest;
                  wr_en = 1'b1; wr_idx = SW'(lp_in - LW'(1));
                  wr_val = over ? 32'd0 : 32'(rest - total);
                  zero_in[wr_idx] = (wr_val == 32'd0);
                  body = (total > 33'd8) ? total - 33'd8 : 33'd0;
                  pay_in = 32'(body);
                  if (over) begin
                     ev_valid_in = 1'b1; ev_in.event_kind = EV_ERROR;
                     ev_in.four_cc = idv; ev_in.chunk_size = szv;
                     ev_in.error_code = ERR_OVERRUN;
                  end
                  if (idv != FCC_LIST) begin
                     if (!over) begin
                        ev_valid_in = 1'b1; ev_in.event_kind = EV_CHUNK;
                        ev_in.four_cc = idv; ev_in.chunk_size = szv;
                     end
                     count_in = '0;
                     if (idv == FCC_NCTG) begin
                        area = (szv < 32'(body)) ? szv : 32'(body);
                        area_in = area; tail_in = 32'(body) - area;
                        if (area != 0) phase_in = PH_TAGHDR;
                        else if (32'(body) != area) phase_in = PH_TAIL;
                        else fin = 1'b1;
                     end else if (body != 0) phase_in = PH_SKIP;
                     else fin = 1'b1;
                  end
               end else if (k == 4'd11) begin
                  inner = (pay_ff > 32'd4) ? pay_ff - 32'd4 : 32'd0;
                  ev_valid_in = 1'b1;
                  ev_in.four_cc = idv; ev_in.chunk_size = szv;
                  count_in = '0;
                  if (lp_in >= LW'(MAX_NEST)) begin
                     ev_in.event_kind = EV_ERROR; ev_in.error_code = ERR_TOO_DEEP;
                     pay_in = inner;
                     if (inner != 0) phase_in = PH_SKIP; else fin = 1'b1;
                  end else begin
                     ev_in.event_kind = EV_LIST;
                     wr_en = 1'b1; wr_idx = SW'(lp_in); wr_val = inner;
                     zero_in[wr_idx] = (inner == 32'd0);
                     lp_in = lp_in + LW'(1);
                     fin = 1'b1;
                  end
               end
            end
            PH_SKIP: begin
               if (pay_ff != 0) pay_in = pay_ff - 32'd1;
               if (pay_in == 0) fin = 1'b1;
            end
            PH_TAGHDR: begin
               if (k[1:0] == 2'd0) begin idv = '0; szv = '0; end
               if (k[1:0] < 2'd2) idv[8*k[0] +: 8] = stream_byte;
               else szv[8*k[0] +: 8] = stream_byte;
               id_in = idv; size_in = szv; count_in = {2'b00, k[1:0]} + 4'd1;
               if (area_ff != 0) area_in = area_ff - 32'd1;
               if (k[1:0] == 2'd3) begin
                  tag_in = idv[15:0];
                  ev_valid_in = 1'b1; ev_in.chunk_size = szv; ev_in.tag_id = idv[15:0];
                  if (szv > area_in) begin
                     ev_in.event_kind = EV_ERROR; ev_in.error_code = ERR_OVERRUN;
                     pay_in = area_in;
                  end else begin
                     ev_in.event_kind = EV_TAG; pay_in = szv;
                  end
                  count_in = '0;
                  if (pay_in != 0) phase_in = PH_TAGDATA;
                  else if (area_in != 0) phase_in = PH_TAGHDR;
                  else if (tail_ff != 0) phase_in = PH_TAIL;
                  else fin = 1'b1;
               end else if (area_in == 0) begin
                  count_in = '0;
                  if (tail_ff != 0) phase_in = PH_TAIL; else fin = 1'b1;
               end
            end
            PH_TAGDATA: begin
               if (pay_ff != 0) pay_in = pay_ff - 32'd1;
               if (area_ff != 0) area_in = area_ff - 32'd1;
               if (tag_ff == date_tag_first || tag_ff == date_tag_second) begin
                  ev_valid_in = 1'b1; ev_in.event_kind = EV_DATE;
                  ev_in.tag_id = tag_ff; ev_in.data_byte = stream_byte;
                  ev_in.last_of_tag = (pay_in == 0);
               end
               if (pay_in == 0) begin
                  count_in = '0;
                  if (area_in != 0) phase_in = PH_TAGHDR;
                  else if (tail_ff != 0) phase_in = PH_TAIL;
                  else fin = 1'b1;
               end
            end
            PH_TAIL: begin
               if (tail_ff != 0) tail_in = tail_ff - 32'd1;
               if (tail_in == 0) fin = 1'b1;
            end
            default: ;
         endcase
         if (fin) begin
            nlp = close_levels(lp_in, zero_in);
            lp_in = nlp; count_in = '0;
            phase_in = (nlp == '0) ? PH_IDLE : PH_CHUNK;
         end
      end else begin
         phase_in = phase_ff; count_in = count_ff; id_in = id_ff; size_in = size_ff;
         lp_in = lp_ff; pay_in = pay_ff; area_in = area_ff; tail_in = tail_ff;
         tag_in = tag_ff; zero_in = zero_ff;
      end
   end

   // Parser state and the registered event.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         count_ff <= '0; id_ff <= '0; size_ff <= '0; lp_ff <= '0;
         pay_ff <= '0; area_ff <= '0; tail_ff <= '0; tag_ff <= '0;
         zero_ff <= '1;
         ev_valid <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in; id_ff <= id_in; size_ff <= size_in; lp_ff <= lp_in;
         pay_ff <= pay_in; area_ff <= area_in; tail_ff <= tail_in; tag_ff <= tag_in;
         zero_ff <= zero_in;
         ev_valid <= byte_valid && ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) ev_data <= ev_in;
      if (byte_valid && wr_en) lvl_ff[wr_idx] <= wr_val;
   end

endmodule

FILE: hdl/rcsp_queue.sv
// Short event queue between the parser and the result port.
module rcsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcsp_pkg::event_type push_data,
   output logic                room,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rcsp_pkg::event_type pop_data
);
   import rcsp_pkg::*;

   localparam int DEPTH = 4;

   event_type   mem_ff [DEPTH];
   logic [1:0]  wr_ff, rd_ff;
   logic [2:0]  cnt_ff;
   logic        pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (cnt_ff != 3'd0);
   assign pop_data  = mem_ff[rd_ff];
   // Two free entries cover the event still in the parser's output register.
   assign room      = (cnt_ff <= 3'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

FILE: hdl/riff_chunk_stream_parser_top.sv
// Top level of the RIFF chunk stream parser.
// One byte is taken per clock while the event queue has room; each byte yields at most one
// event, registered in the parser, through a four-entry queue, so the sustained rate is one
// byte per cycle whenever results are taken as fast. Nesting is kept on MAX_NEST level counters.
module riff_chunk_stream_parser_top #(
   parameter int MAX_NEST = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // stream_byte
   input  logic         req_tuser,   // frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // event_kind, four_cc, chunk_size, nest_level,
                                     // tag_id, data_byte, last_of_tag, error_code
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);
   import rcsp_pkg::*;

   logic [15:0] first_ff, second_ff;
   logic        ev_valid, room;
   event_type   ev_data, out_ev;

   assign req_tready = room;
   assign csr_ready  = 1'b1;

   // Date tag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= DATE_FIRST_RESET;
         second_ff <= DATE_SECOND_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DATE_FIRST:  first_ff  <= csr_data;
            CSR_DATE_SECOND: second_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rcsp_parser #(.MAX_NEST(MAX_NEST)) u_parser (
      .clock, .reset,
      .byte_valid(req_tvalid && room),
      .stream_byte(req_tdata), .frame_start(req_tuser),
      .date_tag_first(first_ff), .date_tag_second(second_ff),
      .ev_valid, .ev_data
   );

   rcsp_queue u_queue (
      .clock, .reset,
      .push(ev_valid), .push_data(ev_data), .room,
      .pop_valid(rsp_tvalid), .pop_ready(rsp_tready), .pop_data(out_ev)
   );

   assign rsp_tdata = {{(104 - EVENT_WIDTH){1'b0}}, out_ev};

endmodule

FILE: hdl/rcsp_checker.sv
// Port-level checks of the RIFF chunk stream parser.
module rcsp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   import rcsp_pkg::*;

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd5) else $error("bad event kind");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(req_tvalid && req_tready) |=> !rsp_tvalid || $past(rsp_tvalid)
      || $past(req_tvalid && req_tready, 2)) else $error("result without input");
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == 3'd0 |-> rsp_tdata[70:67] == 4'd0)
      else $error("riff header with open levels");

endmodule

bind riff_chunk_stream_parser_top rcsp_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
